### rtl/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned W2 = 2 * DATA_WIDTH;
  localparam int unsigned W4 = 4 * DATA_WIDTH;
  localparam int unsigned W6 = 6 * DATA_WIDTH;

  // quotient bits searched per output, one per stage
  localparam int unsigned QBITS = DATA_WIDTH + 1;

  // pcd_mul pipeline depth
  localparam int unsigned MUL_LAT = 3;

  localparam int unsigned KLIM_W = W4 + 4 * FRAC_BITS;
  localparam int unsigned RLIM_W = W4 + 3 * FRAC_BITS;
  localparam int unsigned RDIV_W = W6 + QBITS;
  localparam int unsigned KEXT_W = 8 * DATA_WIDTH + 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  typedef struct packed {
    logic zero;
    logic a_neg;
    logic n_neg;
  } side_t;

endpackage

`default_nettype wire

### rtl/pcd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_mul (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pcd_pkg::W2-1:0]    a_i,
  input  logic [pcd_pkg::W2-1:0]    b_i,
  output logic [pcd_pkg::W4-1:0]    p_o
);

  localparam int unsigned W  = pcd_pkg::DATA_WIDTH;
  localparam int unsigned PW = pcd_pkg::W4;

  logic [2*W-1:0] p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  logic [2*W:0]   mid_q;
  logic [PW-1:0]  outer_q;
  logic [PW-1:0]  p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ll_q  <= a_i[W-1:0] * b_i[W-1:0];
      p_lh_q  <= a_i[W-1:0] * b_i[2*W-1:W];
      p_hl_q  <= a_i[2*W-1:W] * b_i[W-1:0];
      p_hh_q  <= a_i[2*W-1:W] * b_i[2*W-1:W];
      mid_q   <= {1'b0, p_lh_q} + {1'b0, p_hl_q};
      outer_q <= {p_hh_q, p_ll_q};
      p_q     <= outer_q + (PW'(mid_q) << W);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/parametric_curvature_and_derivative_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Curvature and curvature rate of a plane curve from Q16.16 derivatives.
// Fully pipelined: one word per clock in and out. The pipeline is 9 stages of
// products, sums and two chained 64x64 multiplies (built from 32x32 partial
// products), one setup stage, 33 search stages that resolve one quotient
// bit each for both outputs, and the output register.
// Results are truncated toward zero and saturated; status is 0 ok,
// 1 saturated, 2 zero speed (both outputs zero). The finished word sits in
// an output register; input is held off only while that register is stalled
// and the last search stage is full.

module parametric_curvature_and_derivative_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   x_first_i,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   x_second_i,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   x_third_i,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   y_first_i,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   y_second_i,
  input  logic signed [pcd_pkg::DATA_WIDTH-1:0]   y_third_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [pcd_pkg::DATA_WIDTH-1:0]   kappa_o,
  output logic signed [pcd_pkg::DATA_WIDTH-1:0]   kappa_rate_o,
  output logic [1:0]                              status_o
);

  localparam int unsigned W      = pcd_pkg::DATA_WIDTH;
  localparam int unsigned F      = pcd_pkg::FRAC_BITS;
  localparam int unsigned W2     = pcd_pkg::W2;
  localparam int unsigned W4     = pcd_pkg::W4;
  localparam int unsigned W6     = pcd_pkg::W6;
  localparam int unsigned QBITS  = pcd_pkg::QBITS;
  localparam int unsigned LAT    = pcd_pkg::MUL_LAT;
  localparam int unsigned KLIM_W = pcd_pkg::KLIM_W;
  localparam int unsigned RLIM_W = pcd_pkg::RLIM_W;
  localparam int unsigned RDIV_W = pcd_pkg::RDIV_W;
  localparam int unsigned KEXT_W = pcd_pkg::KEXT_W;
  localparam int unsigned SRCH0  = 3 + 2 * LAT;
  localparam int unsigned NSTG   = SRCH0 + QBITS + 1;

  localparam logic [QBITS-1:0] HALF = QBITS'(1) << (W - 1);
  localparam logic [W-1:0]     SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]     SMIN = {1'b1, {(W-1){1'b0}}};

  logic [NSTG-1:0] v_q;
  logic            out_valid_q;
  logic            out_load;
  logic            adv;

  assign out_load   = ~out_valid_q | out_ready_i;
  assign adv        = out_load | ~v_q[NSTG-1];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[NSTG-2:0], in_valid_i};
      end
      if (out_load) begin
        out_valid_q <= v_q[NSTG-1];
      end
    end
  end

  // products
  logic signed [W2-1:0] p_xx_q, p_yy_q, p_xy2_q, p_yx2_q;
  logic signed [W2-1:0] p_xy3_q, p_yx3_q, p_xx2_q, p_yy2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xx_q  <= x_first_i * x_first_i;
      p_yy_q  <= y_first_i * y_first_i;
      p_xy2_q <= x_first_i * y_second_i;
      p_yx2_q <= y_first_i * x_second_i;
      p_xy3_q <= x_first_i * y_third_i;
      p_yx3_q <= y_first_i * x_third_i;
      p_xx2_q <= x_first_i * x_second_i;
      p_yy2_q <= y_first_i * y_second_i;
    end
  end

  // cross terms and squared speed
  logic [W2-1:0]        s2_q;
  logic signed [W2:0]   a_q, ad_q, dd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= $unsigned(p_xx_q) + $unsigned(p_yy_q);
      a_q  <= (W2+1)'(p_xy2_q) - (W2+1)'(p_yx2_q);
      ad_q <= (W2+1)'(p_xy3_q) - (W2+1)'(p_yx3_q);
      dd_q <= (W2+1)'(p_xx2_q) + (W2+1)'(p_yy2_q);
    end
  end

  // magnitudes
  logic [W2-1:0]    s2_2_q, a_mag_q, ad_mag_q, dd_mag_q;
  pcd_pkg::side_t   side2_q;
  logic             ad_neg2_q, u_neg2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_2_q    <= s2_q;
      a_mag_q   <= a_q[W2] ? W2'(-a_q) : W2'(a_q);
      ad_mag_q  <= ad_q[W2] ? W2'(-ad_q) : W2'(ad_q);
      dd_mag_q  <= dd_q[W2] ? W2'(-dd_q) : W2'(dd_q);
      side2_q   <= '{zero: (s2_q == '0), a_neg: a_q[W2], n_neg: 1'b0};
      ad_neg2_q <= ad_q[W2];
      u_neg2_q  <= a_q[W2] ^ dd_q[W2];
    end
  end

  logic [W4-1:0] m_s4, m_a2, m_ads, m_add;

  pcd_mul u_mul_s4  (.clk_i(clk_i), .en_i(adv), .a_i(s2_2_q),   .b_i(s2_2_q),   .p_o(m_s4));
  pcd_mul u_mul_a2  (.clk_i(clk_i), .en_i(adv), .a_i(a_mag_q),  .b_i(a_mag_q),  .p_o(m_a2));
  pcd_mul u_mul_ads (.clk_i(clk_i), .en_i(adv), .a_i(ad_mag_q), .b_i(s2_2_q),   .p_o(m_ads));
  pcd_mul u_mul_add (.clk_i(clk_i), .en_i(adv), .a_i(a_mag_q),  .b_i(dd_mag_q), .p_o(m_add));

  logic [W2-1:0]   d1_s2_q   [0:LAT-1];
  pcd_pkg::side_t  d1_side_q [0:LAT-1];
  logic            d1_adn_q  [0:LAT-1];
  logic            d1_un_q   [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_s2_q[0]   <= s2_2_q;
      d1_side_q[0] <= side2_q;
      d1_adn_q[0]  <= ad_neg2_q;
      d1_un_q[0]   <= u_neg2_q;
      for (int i = 1; i < LAT; i++) begin
        d1_s2_q[i]   <= d1_s2_q[i-1];
        d1_side_q[i] <= d1_side_q[i-1];
        d1_adn_q[i]  <= d1_adn_q[i-1];
        d1_un_q[i]   <= d1_un_q[i-1];
      end
    end
  end

  // s2^3 as two 64x64 halves
  logic [W4-1:0] m_s6h, m_s6l;

  pcd_mul u_mul_s6h (.clk_i(clk_i), .en_i(adv), .a_i(m_s4[W4-1:W2]),
                     .b_i(d1_s2_q[LAT-1]), .p_o(m_s6h));
  pcd_mul u_mul_s6l (.clk_i(clk_i), .en_i(adv), .a_i(m_s4[W2-1:0]),
                     .b_i(d1_s2_q[LAT-1]), .p_o(m_s6l));

  logic [W4-1:0]   d2_a2_q   [0:LAT-1];
  pcd_pkg::side_t  d2_side_q [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_a2_q[0]   <= m_a2;
      d2_side_q[0] <= d1_side_q[LAT-1];
      for (int i = 1; i < LAT; i++) begin
        d2_a2_q[i]   <= d2_a2_q[i-1];
        d2_side_q[i] <= d2_side_q[i-1];
      end
    end
  end

  // numerator of the rate: a_dot s2 - 3 a d
  logic signed [W4:0] tv_q, num_q;
  logic [W4-1:0]      u3_q, nmag_q;
  logic               u_neg6_q, nneg8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tv_q     <= d1_adn_q[LAT-1] ? -$signed({1'b0, m_ads}) : $signed({1'b0, m_ads});
      u3_q     <= m_add + (m_add << 1);
      u_neg6_q <= d1_un_q[LAT-1];
      num_q    <= u_neg6_q ? tv_q + $signed({1'b0, u3_q}) : tv_q - $signed({1'b0, u3_q});
      nmag_q   <= num_q[W4] ? W4'(-num_q) : W4'(num_q);
      nneg8_q  <= num_q[W4];
    end
  end

  // bit search: index j holds the state before quotient bit W-j
  logic [W6-1:0]      s6_q   [0:QBITS];
  logic [KLIM_W-1:0]  kr_q   [0:QBITS];
  logic [RDIV_W-1:0]  kacc_q [0:QBITS];
  logic [QBITS-1:0]   kq_q   [0:QBITS];
  logic [RLIM_W-1:0]  rr_q   [0:QBITS];
  logic [QBITS-1:0]   rq_q   [0:QBITS];
  pcd_pkg::side_t     sd_q   [0:QBITS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q[0]   <= (W6'(m_s6h) << W2) + W6'(m_s6l);
      kr_q[0]   <= KLIM_W'(d2_a2_q[LAT-1]) << (4 * F);
      kacc_q[0] <= '0;
      kq_q[0]   <= '0;
      rr_q[0]   <= RLIM_W'(nmag_q) << (3 * F);
      rq_q[0]   <= '0;
      sd_q[0]   <= '{zero: d2_side_q[LAT-1].zero, a_neg: d2_side_q[LAT-1].a_neg,
                     n_neg: nneg8_q};
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_srch
    localparam int unsigned K = W - j;

    logic [KEXT_W-1:0] k_dlt;
    logic              k_fit;
    logic [RDIV_W-1:0] r_dvs;
    logic              r_fit;

    // (q + 2^K)^2 s6 - q^2 s6 = (q s6) 2^(K+1) + s6 2^(2K)
    assign k_dlt = (KEXT_W'(kacc_q[j]) << (K + 1)) + (KEXT_W'(s6_q[j]) << (2 * K));
    assign k_fit = k_dlt <= KEXT_W'(kr_q[j]);
    assign r_dvs = RDIV_W'(s6_q[j]) << K;
    assign r_fit = r_dvs <= RDIV_W'(rr_q[j]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s6_q[j+1]   <= s6_q[j];
        sd_q[j+1]   <= sd_q[j];
        kr_q[j+1]   <= k_fit ? kr_q[j] - k_dlt[KLIM_W-1:0] : kr_q[j];
        kacc_q[j+1] <= k_fit ? kacc_q[j] + r_dvs : kacc_q[j];
        kq_q[j+1]   <= kq_q[j] | (QBITS'(k_fit) << K);
        rr_q[j+1]   <= r_fit ? rr_q[j] - r_dvs[RLIM_W-1:0] : rr_q[j];
        rq_q[j+1]   <= rq_q[j] | (QBITS'(r_fit) << K);
      end
    end
  end

  // sign, saturation, status
  logic [QBITS-1:0] kq_fin, rq_fin;
  pcd_pkg::side_t   sd_fin;
  logic [W-1:0]     kappa_d, kappa_rate_d;
  logic [1:0]       status_d;
  logic             k_sat, r_sat;

  assign kq_fin = kq_q[QBITS];
  assign rq_fin = rq_q[QBITS];
  assign sd_fin = sd_q[QBITS];

  always_comb begin
    k_sat = 1'b0;
    r_sat = 1'b0;
    if (sd_fin.a_neg) begin
      if (kq_fin > HALF) begin
        kappa_d = SMIN;
        k_sat   = 1'b1;
      end else begin
        kappa_d = W'(-kq_fin);
      end
    end else begin
      if (kq_fin >= HALF) begin
        kappa_d = SMAX;
        k_sat   = 1'b1;
      end else begin
        kappa_d = kq_fin[W-1:0];
      end
    end
    if (sd_fin.n_neg) begin
      if (rq_fin > HALF) begin
        kappa_rate_d = SMIN;
        r_sat        = 1'b1;
      end else begin
        kappa_rate_d = W'(-rq_fin);
      end
    end else begin
      if (rq_fin >= HALF) begin
        kappa_rate_d = SMAX;
        r_sat        = 1'b1;
      end else begin
        kappa_rate_d = rq_fin[W-1:0];
      end
    end
    status_d = (k_sat | r_sat) ? pcd_pkg::ST_SAT : pcd_pkg::ST_OK;
    if (sd_fin.zero) begin
      kappa_d      = '0;
      kappa_rate_d = '0;
      status_d     = pcd_pkg::ST_DEGEN;
    end
  end

  logic [W-1:0] kappa_q, kappa_rate_q;
  logic [1:0]   status_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kappa_q      <= kappa_d;
      kappa_rate_q <= kappa_rate_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kappa_o      = kappa_q;
  assign kappa_rate_o = kappa_rate_q;
  assign status_o     = status_q;

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i && v_q[NSTG-1]))
    else $error("input held off with room in pipeline");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && v_q[NSTG-1]) |=> (v_q == $past(v_q)))
    else $error("pipeline moved while output stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == pcd_pkg::ST_DEGEN) |-> (kappa_q == '0 && kappa_rate_q == '0))
    else $error("zero speed word with nonzero outputs");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == pcd_pkg::ST_SAT) |->
      (kappa_q == SMAX || kappa_q == SMIN || kappa_rate_q == SMAX || kappa_rate_q == SMIN))
    else $error("saturated status without a clamped output");

endmodule

`default_nettype wire
